// ===== rtl/sli_pkg.sv =====
// Shared types and codes for the sorted list insert/delete block.
package sli_pkg;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e               command;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [6:0]         count;
    logic signed [31:0] smallest;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_SCAN,
    S_INS_PUT,
    S_DEL_FIND,
    S_DEL_SHIFT,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_LOAD,
    PTR_CLEAR,
    PTR_INC,
    PTR_DEC
  } ptr_op_e;

  typedef enum logic [1:0] {
    RA_CNT_M1,
    RA_PTR_M2,
    RA_ZERO,
    RA_PTR_P1
  } rd_sel_e;

  typedef enum logic [1:0] {
    WA_ZERO,
    WA_PTR,
    WA_PTR_M1
  } wr_sel_e;

  typedef enum logic {
    WD_VALUE,
    WD_RDATA
  } wd_sel_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  typedef struct packed {
    logic    load;
    ptr_op_e ptr_op;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    wd_sel_e wd_sel;
    cnt_op_e cnt_op;
    logic    st_load;
    status_e st_val;
    logic    res_load;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e command;
    logic cnt_zero;
    logic cnt_full;
    logic ptr_one;
    logic ptr_last;
    logic rd_ge;
    logic rd_eq;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/sli_ctrl.sv =====
// Controller state machine that sequences search and shift passes over the entry memory.
module sli_ctrl
  import sli_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.ptr_op  = PTR_HOLD;
    cmd_o.rd_sel  = RA_ZERO;
    cmd_o.wr_sel  = WA_ZERO;
    cmd_o.wd_sel  = WD_VALUE;
    cmd_o.cnt_op  = CNT_HOLD;
    cmd_o.st_val  = ST_OK;
    in_stall_o    = (state_q != S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        cmd_o.st_load = 1'b1;
        if (stat_i.command == CMD_INSERT) begin
          if (stat_i.cnt_full) begin
            cmd_o.st_val = ST_FULL;
            state_d      = S_DONE;
          end else if (stat_i.cnt_zero) begin
            cmd_o.wr_en  = 1'b1;
            cmd_o.wr_sel = WA_ZERO;
            cmd_o.wd_sel = WD_VALUE;
            cmd_o.cnt_op = CNT_INC;
            state_d      = S_DONE;
          end else begin
            // Start at the top: the free slot is at the count, its lower neighbor is read.
            cmd_o.ptr_op = PTR_LOAD;
            cmd_o.rd_sel = RA_CNT_M1;
            state_d      = S_INS_SCAN;
          end
        end else begin
          if (stat_i.cnt_zero) begin
            cmd_o.st_val = ST_EMPTY;
            state_d      = S_DONE;
          end else begin
            cmd_o.ptr_op = PTR_CLEAR;
            cmd_o.rd_sel = RA_ZERO;
            state_d      = S_DEL_FIND;
          end
        end
      end

      S_INS_SCAN: begin
        // The read data is the entry just below the free slot.
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WA_PTR;
        if (stat_i.rd_ge) begin
          cmd_o.wd_sel = WD_RDATA;
          cmd_o.ptr_op = PTR_DEC;
          cmd_o.rd_sel = RA_PTR_M2;
          if (stat_i.ptr_one) begin
            state_d = S_INS_PUT;
          end
        end else begin
          cmd_o.wd_sel = WD_VALUE;
          cmd_o.cnt_op = CNT_INC;
          state_d      = S_DONE;
        end
      end

      S_INS_PUT: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WA_ZERO;
        cmd_o.wd_sel = WD_VALUE;
        cmd_o.cnt_op = CNT_INC;
        state_d      = S_DONE;
      end

      S_DEL_FIND: begin
        cmd_o.rd_sel = RA_PTR_P1;
        if (stat_i.rd_eq) begin
          if (stat_i.ptr_last) begin
            cmd_o.cnt_op = CNT_DEC;
            state_d      = S_DONE;
          end else begin
            cmd_o.ptr_op = PTR_INC;
            state_d      = S_DEL_SHIFT;
          end
        end else if (stat_i.ptr_last) begin
          cmd_o.st_load = 1'b1;
          cmd_o.st_val  = ST_NOT_FOUND;
          state_d       = S_DONE;
        end else begin
          cmd_o.ptr_op = PTR_INC;
        end
      end

      S_DEL_SHIFT: begin
        // Each arriving entry moves one place down over the removed one.
        cmd_o.rd_sel = RA_PTR_P1;
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WA_PTR_M1;
        cmd_o.wd_sel = WD_RDATA;
        if (stat_i.ptr_last) begin
          cmd_o.cnt_op = CNT_DEC;
          state_d      = S_DONE;
        end else begin
          cmd_o.ptr_op = PTR_INC;
        end
      end

      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/sli_dpath.sv =====
// Datapath: entry memory, count, scan pointer, compare logic and result register.
module sli_dpath
  import sli_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_item_i,
  input  dp_cmd_t   cmd_i,
  output dp_stat_t  stat_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [31:0]        mem_q [DEPTH];
  logic signed [31:0] rdata_q;
  logic signed [31:0] value_q;
  cmd_e               cmd_q;
  logic [AW-1:0]      ptr_q, ptr_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic signed [31:0] smallest_q;
  status_e            st_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic [AW-1:0]      rd_addr, wr_addr;
  logic [31:0]        wr_data;

  always_comb begin
    case (cmd_i.rd_sel)
      RA_CNT_M1: rd_addr = AW'(cnt_q - CW'(1));
      RA_PTR_M2: rd_addr = ptr_q - AW'(2);
      RA_ZERO:   rd_addr = '0;
      RA_PTR_P1: rd_addr = ptr_q + AW'(1);
      default:   rd_addr = '0;
    endcase

    case (cmd_i.wr_sel)
      WA_ZERO:   wr_addr = '0;
      WA_PTR:    wr_addr = ptr_q;
      WA_PTR_M1: wr_addr = ptr_q - AW'(1);
      default:   wr_addr = '0;
    endcase

    wr_data = (cmd_i.wd_sel == WD_RDATA) ? rdata_q : value_q;

    case (cmd_i.ptr_op)
      PTR_LOAD:  ptr_d = AW'(cnt_q);
      PTR_CLEAR: ptr_d = '0;
      PTR_INC:   ptr_d = ptr_q + AW'(1);
      PTR_DEC:   ptr_d = ptr_q - AW'(1);
      default:   ptr_d = ptr_q;
    endcase

    case (cmd_i.cnt_op)
      CNT_INC: cnt_d = cnt_q + CW'(1);
      CNT_DEC: cnt_d = cnt_q - CW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  // Entry memory: up to one write and one registered read each cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (cmd_i.load) begin
      value_q <= in_item_i.value;
      cmd_q   <= in_item_i.command;
    end
    if (cmd_i.st_load) begin
      st_q <= cmd_i.st_val;
    end
    // Any write to the lowest slot also refreshes the cached smallest value.
    if (cmd_i.wr_en && (wr_addr == '0)) begin
      smallest_q <= wr_data;
    end
    if (cmd_i.res_load) begin
      out_q.status   <= st_q;
      out_q.count    <= 7'(cnt_q);
      out_q.smallest <= (cnt_q == '0) ? '0 : smallest_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    stat_o.command  = cmd_q;
    stat_o.cnt_zero = (cnt_q == '0);
    stat_o.cnt_full = (cnt_q == CW'(DEPTH));
    stat_o.ptr_one  = (ptr_q == AW'(1));
    stat_o.ptr_last = ((CW'(ptr_q) + CW'(1)) == cnt_q);
    stat_o.rd_ge    = (rdata_q >= value_q);
    stat_o.rd_eq    = (rdata_q == value_q);
    stat_o.out_free = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== rtl/sorted_list_insert_delete_top.sv =====
// Top level of the sorted list insert/delete block: controller and datapath.
//
//   Channel  Direction  Handshake                Payload
//   in       input      in_valid_i / in_stall_o  in_item_i  (command, value)
//   out      output     out_valid_o / out_stall_i out_item_o (status, count, smallest)
//
// One item is worked at a time. An insert walks down from the top entry and a delete
// walks up from the bottom entry, moving one entry per cycle through the single write
// port of the entry memory.
// Reset clears the entry count, the output valid and the controller state; the memory needs no clearing pass.
// in_stall_o is high from acceptance until the result enters the output register,
// which holds it for as long as out_stall_i is high.
module sorted_list_insert_delete_top
  import sli_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  sli_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  sli_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
